FILE: hw/rtl/dcx_pkg.sv
package dcx_pkg;

  localparam int MAX_PAGES_DEF      = 1024;
  localparam int MIN_PAGE_BYTES_DEF = 128;

  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int INDEX_W  = 10;
  localparam int REG_IDX_W = 1;

  localparam logic [WORD_W-1:0] MAGIC_RESET = 32'd987654321;

  localparam logic [REG_IDX_W-1:0] REG_FILE_LENGTH = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MAGIC_VALUE = 1'b1;

  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_INVALID = 2'd2,
    ST_NODIR   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OUT_PLAIN,  // given status, no count, no span
    OUT_COUNT,  // given status with the page count
    OUT_CHECK,  // directory check verdict
    OUT_SPAN    // page span query answer
  } out_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VINIT,
    S_QSTART,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic      clear_count;
    logic      store;
    logic      read_index;
    logic      scan_init;
    logic      scan_query;
    logic      scan_step;
    logic      out_load;
    out_kind_t out_kind;
    status_t   out_status;
  } dcx_cmd_t;

  typedef struct packed {
    logic fl_lt4;
    logic fl_lt8;
    logic magic_eq;
    logic word_zero;
    logic count_zero;
    logic at_max;
    logic store_full;
    logic store_trunc;
    logic idx_ok;
    logic scan_done;
    logic val_ok;
  } dcx_stat_t;

endpackage

FILE: hw/rtl/dcx_datapath.sv
module dcx_datapath
  import dcx_pkg::*;
#(
  parameter int MIN_PAGE_BYTES = MIN_PAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [WORD_W-1:0]    wr_data,
  input  logic [WORD_W-1:0]    header_word,
  input  logic [INDEX_W-1:0]   page_index,
  input  dcx_cmd_t             cmd,
  output dcx_stat_t            stat,
  output logic [1:0]           status,
  output logic [COUNT_W-1:0]   page_count,
  output logic [WORD_W-1:0]    page_start,
  output logic [WORD_W-1:0]    page_stop
);

  // store depth is tied to the port widths of the page index and count
  localparam int MAX_PAGES = MAX_PAGES_DEF;
  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);

  logic [WORD_W-1:0] file_length;
  logic [WORD_W-1:0] magic_value;
  logic [CW-1:0]     count;
  logic [CW-1:0]     scan_addr;
  logic              rd_vld;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] dir_end;
  logic [WORD_W-1:0] span_start;
  logic [WORD_W-1:0] span_stop;
  status_t           fail;

  logic [WORD_W-1:0] mem [MAX_PAGES];

  logic [AW-1:0]     rd_addr;
  logic [CW-1:0]     n_sel;
  logic [WORD_W-3:0] slots;
  logic              over_end;

  assign rd_addr = cmd.read_index ? AW'(page_index) : scan_addr[AW-1:0];
  // entries that still fit after the magic: (len - 4) / 4
  assign slots   = (file_length < 32'd4) ? '0 :
                   (file_length[WORD_W-1:2] - (WORD_W-2)'(1));
  assign n_sel   = (count < CW'(MAX_PAGES)) ? CW'(count + CW'(1)) : count;
  // offset + min page > length covers the short-file case too
  assign over_end = ({1'b0, rdata} + (WORD_W+1)'(MIN_PAGE_BYTES)) > {1'b0, file_length};

  always_comb begin
    stat.fl_lt4      = file_length < 32'd4;
    stat.fl_lt8      = file_length < 32'd8;
    stat.magic_eq    = header_word == magic_value;
    stat.word_zero   = header_word == '0;
    stat.count_zero  = count == '0;
    stat.at_max      = count == CW'(MAX_PAGES);
    stat.store_full  = count == CW'(MAX_PAGES - 1);
    stat.store_trunc = 32'(slots) <= (32'(count) + 32'd1);
    stat.idx_ok      = 32'(page_index) < 32'(count);
    stat.scan_done   = scan_addr == count;
    stat.val_ok      = fail == ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
      magic_value <= MAGIC_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FILE_LENGTH: file_length <= wr_data;
        REG_MAGIC_VALUE: magic_value <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (cmd.store) begin
      count <= CW'(count + CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count[AW-1:0]] <= header_word;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_step && !stat.scan_done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_addr <= '0;
      fail      <= ST_OK;
      dir_end   <= 32'd4 + (32'(n_sel) << 2);
      if (cmd.scan_query) begin
        span_start <= rdata;
        span_stop  <= file_length;
      end
    end else if (cmd.scan_step && !stat.scan_done) begin
      scan_addr <= CW'(scan_addr + CW'(1));
    end
    if (rd_vld) begin
      if (cmd.scan_query) begin
        if (rdata > span_start && rdata < span_stop) begin
          span_stop <= rdata;
        end
      end else if (fail == ST_OK) begin
        // first failing offset decides
        if (rdata < dir_end) begin
          fail <= ST_INVALID;
        end else if (over_end) begin
          fail <= ST_TRUNC;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        OUT_PLAIN: begin
          status     <= cmd.out_status;
          page_count <= '0;
          page_start <= '0;
          page_stop  <= '0;
        end
        OUT_COUNT: begin
          status     <= cmd.out_status;
          page_count <= COUNT_W'(count);
          page_start <= '0;
          page_stop  <= '0;
        end
        OUT_CHECK: begin
          status     <= fail;
          page_count <= (fail == ST_OK) ? COUNT_W'(count) : '0;
          page_start <= '0;
          page_stop  <= '0;
        end
        default: begin
          status     <= ST_OK;
          page_count <= COUNT_W'(count);
          page_start <= span_start;
          page_stop  <= span_stop;
        end
      endcase
    end
  end

  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (count < CW'(MAX_PAGES)))
    else $error("offset store written past its depth");

  a_read_follows_step: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(cmd.scan_step))
    else $error("scan data valid without a scan step");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PAGES))
    else $error("entry count beyond store depth");

endmodule

FILE: hw/rtl/dcx_ctrl.sv
module dcx_ctrl
  import dcx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      func,
  input  logic      first_word,
  output logic      out_valid,
  input  logic      out_stall,
  input  dcx_stat_t stat,
  output dcx_cmd_t  cmd
);

  state_t state, state_next;
  logic   collect, collect_next;
  logic   good, good_next;
  logic   query_mode, query_mode_next;
  logic   out_valid_next;
  logic   slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      collect    <= 1'b0;
      good       <= 1'b0;
      query_mode <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      collect    <= collect_next;
      good       <= good_next;
      query_mode <= query_mode_next;
      out_valid  <= out_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    collect_next    = collect;
    good_next       = good;
    query_mode_next = query_mode;
    cmd             = '0;
    cmd.scan_query  = query_mode;
    slot_free       = !out_valid || !out_stall;
    // take a word only when a result it may cause has room
    in_stall        = (state != S_IDLE) || !slot_free;

    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          if (func == FUNC_HEADER) begin
            if (first_word) begin
              cmd.clear_count = 1'b1;
              good_next       = 1'b0;
              collect_next    = 1'b0;
              if (stat.fl_lt4) begin
                cmd.out_load   = 1'b1;
                cmd.out_kind   = OUT_PLAIN;
                cmd.out_status = ST_TRUNC;
              end else if (!stat.magic_eq) begin
                cmd.out_load   = 1'b1;
                cmd.out_kind   = OUT_PLAIN;
                cmd.out_status = ST_INVALID;
              end else if (stat.fl_lt8) begin
                // no room for even one entry
                cmd.out_load   = 1'b1;
                cmd.out_kind   = OUT_PLAIN;
                cmd.out_status = ST_TRUNC;
              end else begin
                collect_next = 1'b1;
              end
            end else if (collect) begin
              if (stat.word_zero) begin
                collect_next = 1'b0;
                if (stat.count_zero) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_kind   = OUT_PLAIN;
                  cmd.out_status = ST_INVALID;
                end else begin
                  query_mode_next = 1'b0;
                  state_next      = S_VINIT;
                end
              end else if (stat.at_max) begin
                collect_next    = 1'b0;
                query_mode_next = 1'b0;
                state_next      = S_VINIT;
              end else begin
                cmd.store = 1'b1;
                if (stat.store_full) begin
                  collect_next    = 1'b0;
                  query_mode_next = 1'b0;
                  state_next      = S_VINIT;
                end else if (stat.store_trunc) begin
                  collect_next   = 1'b0;
                  cmd.out_load   = 1'b1;
                  cmd.out_kind   = OUT_PLAIN;
                  cmd.out_status = ST_TRUNC;
                end
              end
            end
          end else begin
            if (!good) begin
              cmd.out_load   = 1'b1;
              cmd.out_kind   = OUT_PLAIN;
              cmd.out_status = ST_NODIR;
            end else if (!stat.idx_ok) begin
              cmd.out_load   = 1'b1;
              cmd.out_kind   = OUT_COUNT;
              cmd.out_status = ST_INVALID;
            end else begin
              cmd.read_index  = 1'b1;
              query_mode_next = 1'b1;
              state_next      = S_QSTART;
            end
          end
        end
      end
      S_VINIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_QSTART: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = query_mode ? OUT_SPAN : OUT_CHECK;
          if (!query_mode) begin
            good_next = stat.val_ok;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    out_valid_next = cmd.out_load ? 1'b1 : (slot_free ? 1'b0 : out_valid);
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> slot_free)
    else $error("result register loaded while a word is pending");

  a_store_when_collecting: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (collect && state == S_IDLE))
    else $error("offset stored outside directory collection");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && slot_free) |=> (out_valid && state == S_IDLE))
    else $error("scan result not presented");

  a_query_needs_dir: assert property (@(posedge clk) disable iff (rst)
    (state == S_QSTART) |-> good)
    else $error("span query started without a good directory");

endmodule

FILE: hw/rtl/dcx_directory_parser.sv
// Header words are taken while in_stall is low; a result, when one is due, is valid the next cycle.
// Directory check: after the closing word the control steps through S_VINIT, S_SCAN
//   and S_EMIT, one read of the offset memory port per cycle over the n stored offsets.
// Page query: S_QSTART, S_SCAN and S_EMIT over the same memory scan; immediate answers are valid the next cycle.
// One item is in work at a time. Sync reset clears control, the entry count
//   and the registers (magic to its default); the offset memory is not cleared.
module dcx_directory_parser
  import dcx_pkg::*;
#(
  parameter int MIN_PAGE_BYTES = MIN_PAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [WORD_W-1:0]    wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic                 first_word,
  input  logic [WORD_W-1:0]    header_word,
  input  logic [INDEX_W-1:0]   page_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [COUNT_W-1:0]   page_count,
  output logic [WORD_W-1:0]    page_start,
  output logic [WORD_W-1:0]    page_stop
);

  dcx_cmd_t  cmd;
  dcx_stat_t stat;

  dcx_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .first_word (first_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  dcx_datapath #(
    .MIN_PAGE_BYTES (MIN_PAGE_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .header_word (header_word),
    .page_index  (page_index),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .page_count  (page_count),
    .page_start  (page_start),
    .page_stop   (page_stop)
  );

endmodule

FILE: dv/tb_dcx_directory_parser.sv
`timescale 1ns / 100ps

module tb_dcx_directory_parser;
  import dcx_pkg::*;

  localparam int                  NPAGES     = MAX_PAGES_DEF;
  localparam bit [63:0]           MIN_SPAN   = 64'(MIN_PAGE_BYTES_DEF);
  localparam int                  LONG_HOLD  = 150;
  localparam int                  IDLE_LIMIT = 6000;
  localparam logic [WORD_W-1:0]   ALL_ONES   = 32'hFFFF_FFFF;

  typedef enum {WALK_IDLE, WALK_COLLECT, WALK_DONE} walk_t;

  typedef struct {
    status_t          st;
    bit [COUNT_W-1:0] count;
    bit [WORD_W-1:0]  start;
    bit [WORD_W-1:0]  stop;
  } reply_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 wr_en       = 1'b0;
  logic [REG_IDX_W-1:0] wr_index    = '0;
  logic [WORD_W-1:0]    wr_data     = '0;
  logic                 in_valid    = 1'b0;
  logic                 func        = FUNC_HEADER;
  logic                 first_word  = 1'b0;
  logic [WORD_W-1:0]    header_word = '0;
  logic [INDEX_W-1:0]   page_index  = '0;
  logic                 out_stall   = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [1:0]           status;
  logic [COUNT_W-1:0]   page_count;
  logic [WORD_W-1:0]    page_start;
  logic [WORD_W-1:0]    page_stop;

  dcx_directory_parser dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .first_word (first_word),
    .header_word(header_word),
    .page_index (page_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .page_count (page_count),
    .page_start (page_start),
    .page_stop  (page_stop)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirror of the parser state and registers
  bit [WORD_W-1:0] len_reg   = '0;
  bit [WORD_W-1:0] magic_reg = MAGIC_RESET;
  bit [WORD_W-1:0] offs [NPAGES];
  int              n_offs    = 0;
  walk_t           walk      = WALK_IDLE;
  bit              dir_ok    = 1'b0;

  reply_t answers_due[$];
  reply_t due;
  int     errors      = 0;
  int     words_sent  = 0;
  bit     quiet       = 1'b0;
  bit     hold_req    = 1'b0;
  int     rx_wait     = 0;
  int     rx_hold     = 0;
  int     idle_cycles = 0;

  function automatic bit verdict(input status_t st, input bit [COUNT_W-1:0] cnt,
                                 output reply_t r);
    r.st    = st;
    r.count = cnt;
    r.start = '0;
    r.stop  = '0;
    return 1'b1;
  endfunction

  function automatic bit [63:0] room_left();
    return (len_reg < 4) ? 64'd0 : ({32'd0, len_reg} - 64'd4) / 64'd4;
  endfunction

  function automatic bit close_directory(output reply_t r);
    bit [63:0] dir_end;
    bit [63:0] len64;
    bit [63:0] off;
    int        i;
    dir_end = 64'(4 + 4 * ((n_offs < NPAGES) ? n_offs + 1 : n_offs));
    len64   = {32'd0, len_reg};
    walk    = WALK_DONE;
    // first failing offset in directory order decides
    for (i = 0; i < n_offs; i++) begin
      off = {32'd0, offs[i]};
      if (off < dir_end)
        return verdict(ST_INVALID, '0, r);
      if (len64 < MIN_SPAN || off > len64 - MIN_SPAN)
        return verdict(ST_TRUNC, '0, r);
    end
    dir_ok = 1'b1;
    return verdict(ST_OK, n_offs[COUNT_W-1:0], r);
  endfunction

  function automatic bit dir_answer(input logic f, input logic first,
                                    input logic [WORD_W-1:0] w,
                                    input logic [INDEX_W-1:0] idx, output reply_t r);
    bit [WORD_W-1:0] lo;
    bit [WORD_W-1:0] hi;
    int              i;
    r = '{ST_OK, '0, '0, '0};
    if (f == FUNC_QUERY) begin
      if (!dir_ok)
        return verdict(ST_NODIR, '0, r);
      if (idx >= n_offs)
        return verdict(ST_INVALID, n_offs[COUNT_W-1:0], r);
      lo = offs[idx];
      hi = len_reg;
      for (i = 0; i < n_offs; i++)
        if (offs[i] > lo && offs[i] < hi)
          hi = offs[i];
      r.st    = ST_OK;
      r.count = n_offs[COUNT_W-1:0];
      r.start = lo;
      r.stop  = hi;
      return 1'b1;
    end
    if (first) begin
      dir_ok = 1'b0;
      n_offs = 0;
      walk   = WALK_DONE;
      if (len_reg < 4)
        return verdict(ST_TRUNC, '0, r);
      if (w != magic_reg)
        return verdict(ST_INVALID, '0, r);
      if (room_left() == 0)
        return verdict(ST_TRUNC, '0, r);
      walk = WALK_COLLECT;
      return 1'b0;
    end
    if (walk != WALK_COLLECT)
      return 1'b0;
    if (w == '0) begin
      if (n_offs == 0) begin
        walk = WALK_DONE;
        return verdict(ST_INVALID, '0, r);
      end
      return close_directory(r);
    end
    offs[n_offs] = w;
    n_offs++;
    if (n_offs >= NPAGES)
      return close_directory(r);
    if (room_left() <= n_offs) begin
      walk = WALK_DONE;
      return verdict(ST_TRUNC, '0, r);
    end
    return 1'b0;
  endfunction

  task automatic offer_word(input logic f, input logic first, input logic [WORD_W-1:0] w,
                            input logic [INDEX_W-1:0] idx);
    int     gap;
    reply_t r;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    first_word  <= first;
    header_word <= w;
    page_index  <= idx;
    do @(posedge clk); while (in_stall);
    // stray header words outside a parse are dropped by the block
    if (!(f == FUNC_HEADER && !first && walk != WALK_COLLECT))
      words_sent++;
    if (dir_answer(f, first, w, idx, r))
      answers_due.push_back(r);
  endtask

  task automatic send_header(input logic first, input logic [WORD_W-1:0] w);
    offer_word(FUNC_HEADER, first, w, INDEX_W'($urandom_range(0, 1023)));
  endtask

  task automatic send_query(input logic [INDEX_W-1:0] idx);
    offer_word(FUNC_QUERY, 1'($urandom_range(0, 1)), $urandom(), idx);
  endtask

  // hold input low until every expected result is back, then let the clock run on
  // so that a header word that gives no result is also through
  task automatic settle();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    settle();
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_FILE_LENGTH)
      len_reg = val;
    else
      magic_reg = val;
  endtask

  task automatic test_magic_handling();
    send_query(10'd0);
    send_header(1'b0, 32'h1234_5678);
    send_header(1'b1, MAGIC_RESET);          // file length still zero
    write_reg(REG_FILE_LENGTH, 32'd3);
    send_header(1'b1, MAGIC_RESET);
    write_reg(REG_FILE_LENGTH, 32'd7);       // magic fits, no room for an entry
    send_header(1'b1, MAGIC_RESET);
    write_reg(REG_FILE_LENGTH, ALL_ONES);
    send_header(1'b1, ~MAGIC_RESET);
    send_header(1'b1, MAGIC_RESET);
    send_header(1'b0, 32'd0);                // empty directory
    write_reg(REG_MAGIC_VALUE, 32'd0);
    send_header(1'b1, 32'd0);
    send_header(1'b0, ALL_ONES - 32'd128);   // last legal offset
    send_header(1'b0, 32'd0);
    send_query(10'd0);
    write_reg(REG_MAGIC_VALUE, ALL_ONES);
    send_header(1'b1, ALL_ONES);
    send_header(1'b0, ALL_ONES - 32'd127);
    send_header(1'b0, 32'd0);
    write_reg(REG_MAGIC_VALUE, MAGIC_RESET);
  endtask

  task automatic test_directory_checks();
    write_reg(REG_FILE_LENGTH, 32'd1000);
    send_header(1'b1, magic_reg);
    send_header(1'b0, 32'd20);               // exactly at directory end
    send_header(1'b0, 32'd872);
    send_header(1'b0, 32'd500);
    send_header(1'b0, 32'd0);
    send_query(10'd0);
    send_query(10'd1);
    send_query(10'd1023);
    send_header(1'b1, magic_reg);
    send_header(1'b0, 32'd7);                // inside the directory
    send_header(1'b0, 32'd0);
    write_reg(REG_FILE_LENGTH, 32'd12);      // room for two entries only
    send_header(1'b1, magic_reg);
    send_header(1'b0, 32'd20);
    send_header(1'b0, 32'd24);
    write_reg(REG_FILE_LENGTH, 32'd1000);
    send_header(1'b1, magic_reg);
    send_header(1'b0, 32'd600);
    write_reg(REG_FILE_LENGTH, 32'd100);     // shrinks mid-parse, below one page
    send_header(1'b0, 32'd0);
  endtask

  task automatic test_full_directory();
    int i;
    write_reg(REG_FILE_LENGTH, ALL_ONES);
    send_header(1'b1, magic_reg);
    for (i = 0; i < NPAGES; i++)
      send_header(1'b0, $urandom_range(ALL_ONES - 32'd128, 4 + 4 * NPAGES));
    send_header(1'b0, 32'd0);                // directory already closed
    send_query(10'd1023);
    send_query(10'd0);
    repeat (4) send_query(INDEX_W'($urandom_range(0, 1023)));
    settle();
  endtask

  task automatic test_backpressure();
    write_reg(REG_FILE_LENGTH, 32'd4096);
    send_header(1'b1, magic_reg);
    repeat (3) send_header(1'b0, $urandom_range(4096 - 128, 20));
    send_header(1'b0, 32'd0);
    settle();
    quiet    = 1'b1;
    hold_req = 1'b1;
    repeat (16) send_query(INDEX_W'($urandom_range(0, 3)));
    quiet = 1'b0;
    settle();
  endtask

  task automatic test_random(input int goal);
    int              base;
    int              n;
    int              bad;
    int              i;
    int              shape;
    bit [WORD_W-1:0] dir_end;
    bit [WORD_W-1:0] len;
    bit [WORD_W-1:0] w;
    base = words_sent;
    while (words_sent - base < goal) begin
      quiet = ($urandom_range(0, 4) == 0);
      shape = $urandom_range(0, 19);
      if (shape < 3) begin
        repeat ($urandom_range(1, 6))
          offer_word(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, $urandom(),
                     INDEX_W'($urandom_range(0, 1023)));
      end else begin
        n       = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        dir_end = 4 + 4 * (n + 1);
        if (shape == 3)
          len = $urandom_range(dir_end - 1, 0);     // too short, parse breaks off
        else if (shape == 4)
          len = $urandom_range(ALL_ONES, dir_end + 128);
        else
          len = dir_end + 128 + $urandom_range(0, 4096);
        if (len != len_reg)
          write_reg(REG_FILE_LENGTH, len);
        if ($urandom_range(0, 7) == 0)
          write_reg(REG_MAGIC_VALUE, $urandom());
        bad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
        send_header(1'b1, ($urandom_range(0, 15) == 0) ? $urandom() : magic_reg);
        for (i = 0; i < n; i++) begin
          if (i == bad)
            w = $urandom_range(0, 1) ? $urandom_range(dir_end - 1, 1)
                                     : $urandom_range(ALL_ONES, len - 127);
          else
            w = $urandom_range(len - 128, dir_end);
          if (w == '0)
            w = dir_end;
          send_header(1'b0, w);
          if ($urandom_range(0, 15) == 0)
            send_query(INDEX_W'($urandom_range(0, 1023)));
        end
        if ($urandom_range(0, 7) != 0)
          send_header(1'b0, 32'd0);
        repeat ($urandom_range(0, 5))
          send_query(INDEX_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, n - 1)));
      end
    end
    quiet = 1'b0;
  endtask

  // receiver: random wait per word, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (hold_req && rx_hold == 0) begin
        rx_hold  = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        out_stall <= (rx_hold != 0);
      end else begin
        if (out_valid && !out_stall)
          rx_wait = quiet ? 0 : $urandom_range(0, 5);
        else if (rx_wait > 0)
          rx_wait = rx_wait - 1;
        out_stall <= (rx_wait != 0);
      end
    end
  end

  function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, got status %0d count %0d span %0h..%0h",
                 $time, status, page_count, page_start, page_stop);
        errors++;
      end else begin
        due = answers_due.pop_front();
        check_field("status", WORD_W'(due.st), WORD_W'(status));
        check_field("page_count", WORD_W'(due.count), WORD_W'(page_count));
        check_field("page_start", due.start, page_start);
        check_field("page_stop", due.stop, page_stop);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** dcx_directory_parser: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_magic_handling();
    test_directory_checks();
    test_backpressure();
    test_random(520);
    test_full_directory();
    settle();
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("** dcx_directory_parser: PASSED **");
    else
      $display("** dcx_directory_parser: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dcx_pkg.sv
hw/rtl/dcx_datapath.sv
hw/rtl/dcx_ctrl.sv
hw/rtl/dcx_directory_parser.sv
dv/tb_dcx_directory_parser.sv
